// ===== rtl/core/event_flag_unit_defines.svh =====
// Assertion macros shared by the event flag unit RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef EVENT_FLAG_UNIT_DEFINES_SVH
`define EVENT_FLAG_UNIT_DEFINES_SVH
`ifndef SYNTH
`define EFU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define EFU_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EFU_ASSERT(label, clk, rst_n, prop)
`define EFU_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/core/efu_pkg.sv =====
// Package for the event flag unit: widths, codes and shared types.
// Depends on nothing.
`timescale 1ns / 1ps
package efu_pkg;
    localparam int WaiterSlotsDef = 16;
    localparam int TagBitsDef = 8;
    localparam int PatW = 64;
    localparam int ModeW = 6;
    localparam int KindW = 3;
    localparam int OutTagW = 8;
    localparam int CfgIdxW = 1;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_CLEAR = 2'd1,
        OP_WAIT = 2'd2,
        OP_POLL = 2'd3
    } t_op;

    typedef enum logic [KindW-1:0] {
        K_MET = 3'd0,
        K_WOKEN = 3'd1,
        K_PARKED = 3'd2,
        K_BUSY = 3'd3,
        K_REFUSED = 3'd4,
        K_BADMODE = 3'd5,
        K_FULL = 3'd6,
        K_DONE = 3'd7
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INITIAL = 1'b0,
        CFG_MULTI = 1'b1
    } t_cfg_idx;

    localparam int ModeAndBit = 0;
    localparam int ModeOrBit = 1;
    localparam int ModeClrAllBit = 4;
    localparam int ModeClrOwnBit = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_DONE
    } t_state;

    function automatic logic f_cond(input logic [PatW-1:0] flags,
                                    input logic [PatW-1:0] mask,
                                    input logic [ModeW-1:0] mode);
        if (mode[ModeAndBit]) begin
            return (flags & mask) == mask;
        end
        return (flags & mask) != '0;
    endfunction

    function automatic logic [PatW-1:0] f_clear(input logic [PatW-1:0] flags,
                                                input logic [PatW-1:0] mask,
                                                input logic [ModeW-1:0] mode);
        if (mode[ModeClrAllBit]) begin
            return '0;
        end else if (mode[ModeClrOwnBit]) begin
            return flags & ~mask;
        end
        return flags;
    endfunction
endpackage

// ===== rtl/core/efu_if.sv =====
// Valid/ready channel interfaces for the event flag unit.
// Depends on efu_pkg.
`timescale 1ns / 1ps
interface efu_in_if import efu_pkg::*; #(parameter int TAG_BITS = TagBitsDef);
    logic valid;
    logic ready;
    logic [1:0] op;
    logic [PatW-1:0] pattern;
    logic [ModeW-1:0] wmode;
    logic [TAG_BITS-1:0] tag;
    modport source (output valid, op, pattern, wmode, tag, input ready);
    modport sink (input valid, op, pattern, wmode, tag, output ready);
endinterface

interface efu_out_if import efu_pkg::*; #(parameter int TAG_BITS = TagBitsDef);
    logic valid;
    logic ready;
    logic [KindW-1:0] kind;
    logic [TAG_BITS-1:0] waiter_tag;
    logic [PatW-1:0] result_pattern;
    logic last;
    modport source (output valid, kind, waiter_tag, result_pattern, last, input ready);
    modport sink (input valid, kind, waiter_tag, result_pattern, last, output ready);
endinterface

interface efu_cfg_if import efu_pkg::*;;
    logic valid;
    logic ready;
    logic [CfgIdxW-1:0] index;
    logic [PatW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/efu_queue.sv =====
// Short command queue between the front end and the executor.
// Depends on efu_pkg.
`timescale 1ns / 1ps
module efu_queue import efu_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PtrW = $clog2(QueueDepth);
    logic [WIDTH-1:0] r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0] r_cnt;

    assign o_full = r_cnt == (PtrW+1)'(QueueDepth);
    assign o_empty = r_cnt == '0;
    assign o_data = r_mem[r_rd];

    // advance pointers on transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(i_push && !o_full) - (PtrW+1)'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_data;
    end
endmodule

// ===== rtl/core/efu_front.sv =====
// Front end: accepts commands and tags them with an early bad-mode flag.
// Depends on efu_pkg and efu_queue.
`timescale 1ns / 1ps
module efu_front import efu_pkg::*; #(
    parameter int TAG_BITS = TagBitsDef,
    parameter int QW = 2 + PatW + ModeW + TAG_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    efu_in_if.sink        in_ch,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [QW-1:0] o_cmd
);
    logic q_full;
    logic bad_mode;

    // flag modes with neither AND nor OR while still at the door
    assign bad_mode = !(in_ch.wmode[ModeAndBit] || in_ch.wmode[ModeOrBit]);
    assign in_ch.ready = !q_full;

    efu_queue #(.WIDTH(QW)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(in_ch.valid),
        .i_data({in_ch.op, in_ch.pattern, in_ch.wmode, in_ch.tag, bad_mode}),
        .o_full(q_full), .i_pop(i_pop), .o_empty(o_empty), .o_data(o_cmd)
    );
endmodule

// ===== rtl/core/efu_back.sv =====
// Back end: executes commands on the flag pattern and the waiter table.
// Depends on efu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "event_flag_unit_defines.svh"
module efu_back import efu_pkg::*; #(
    parameter int WAITER_SLOTS = WaiterSlotsDef,
    parameter int TAG_BITS = TagBitsDef,
    parameter int QW = 2 + PatW + ModeW + TAG_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    efu_cfg_if.sink       cfg_ch,
    input  logic          i_empty,
    input  logic [QW-1:0] i_cmd,
    output logic          o_pop,
    efu_out_if.source     out_ch
);
    localparam int IdxW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CntW = $clog2(WAITER_SLOTS + 1);

    logic [1:0] c_op;
    logic [PatW-1:0] c_pat;
    logic [ModeW-1:0] c_mode;
    logic [TAG_BITS-1:0] c_tag;
    logic c_bad;
    assign {c_op, c_pat, c_mode, c_tag, c_bad} = i_cmd;

    logic [PatW-1:0] r_masks [WAITER_SLOTS];
    logic [ModeW-1:0] r_modes [WAITER_SLOTS];
    logic [TAG_BITS-1:0] r_ids [WAITER_SLOTS];

    t_state r_state, n_state;
    logic [PatW-1:0] r_flags, n_flags;
    logic r_multi;
    logic [CntW-1:0] r_count, n_count, r_rd, n_rd, r_wr, n_wr;
    logic r_ov, n_ov;
    t_kind r_kind, n_kind;
    logic [TAG_BITS-1:0] r_otag, n_otag;
    logic [PatW-1:0] r_opat, n_opat;
    logic r_last, n_last;

    logic cfg_hit, out_go, start, scan_hit, mv_en;
    logic [IdxW-1:0] rd_idx, wr_idx;
    logic [PatW-1:0] e_mask;
    logic [ModeW-1:0] e_mode;
    logic [TAG_BITS-1:0] e_id;

    assign cfg_ch.ready = 1'b1;
    assign cfg_hit = cfg_ch.valid;
    assign out_go = !r_ov || out_ch.ready;
    assign rd_idx = r_rd[IdxW-1:0];
    assign wr_idx = r_wr[IdxW-1:0];
    assign e_mask = r_masks[rd_idx];
    assign e_mode = r_modes[rd_idx];
    assign e_id = r_ids[rd_idx];
    assign scan_hit = f_cond(r_flags, e_mask, e_mode);

    assign out_ch.valid = r_ov;
    assign out_ch.kind = r_kind;
    assign out_ch.waiter_tag = r_otag;
    assign out_ch.result_pattern = r_opat;
    assign out_ch.last = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_empty && out_go && c_op == OP_SET) n_state = S_SCAN;
            S_SCAN: begin
                if (r_rd >= r_count) n_state = S_DONE;
                else if (scan_hit) n_state = S_EMIT;
            end
            S_EMIT: if (out_go) n_state = S_SCAN;
            S_DONE: if (out_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_flags = r_flags;
        n_count = r_count;
        n_rd = r_rd;
        n_wr = r_wr;
        n_ov = r_ov && !out_ch.ready;
        n_kind = r_kind;
        n_otag = r_otag;
        n_opat = r_opat;
        n_last = r_last;
        o_pop = 1'b0;
        mv_en = 1'b0;
        start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && out_go) begin
                    o_pop = 1'b1;
                    start = 1'b1;
                    n_ov = 1'b1;
                    n_otag = c_tag;
                    n_opat = '0;
                    n_last = 1'b1;
                    case (t_op'(c_op))
                        OP_SET: begin
                            n_flags = r_flags | c_pat;
                            n_rd = '0;
                            n_wr = '0;
                            n_ov = r_ov && !out_ch.ready;
                        end
                        OP_CLEAR: begin
                            n_flags = r_flags & c_pat;
                            n_kind = K_DONE;
                            n_otag = '0;
                            n_opat = r_flags & c_pat;
                        end
                        default: begin
                            if (!r_multi && r_count != '0) n_kind = K_REFUSED;
                            else if (c_bad) n_kind = K_BADMODE;
                            else if (f_cond(r_flags, c_pat, c_mode)) begin
                                n_kind = K_MET;
                                n_opat = r_flags;
                                n_flags = f_clear(r_flags, c_pat, c_mode);
                            end else if (c_op == OP_POLL) n_kind = K_BUSY;
                            else if (r_count >= CntW'(WAITER_SLOTS)) n_kind = K_FULL;
                            else begin
                                n_kind = K_PARKED;
                                n_count = r_count + 1'b1;
                                mv_en = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd < r_count) begin
                    // compact survivors towards the head
                    if (!scan_hit) begin
                        mv_en = 1'b1;
                        n_wr = r_wr + 1'b1;
                    end
                    n_rd = r_rd + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_go) begin
                    n_ov = 1'b1;
                    n_kind = K_WOKEN;
                    n_otag = r_ids[IdxW'(r_rd - 1'b1)];
                    n_opat = r_flags;
                    n_last = 1'b0;
                    n_flags = f_clear(r_flags, r_masks[IdxW'(r_rd - 1'b1)],
                                      r_modes[IdxW'(r_rd - 1'b1)]);
                end
            end
            S_DONE: begin
                if (out_go) begin
                    n_ov = 1'b1;
                    n_kind = K_DONE;
                    n_otag = '0;
                    n_opat = r_flags;
                    n_last = 1'b1;
                    n_count = r_wr;
                end
            end
            default: ;
        endcase
        if (cfg_hit && cfg_ch.index == CFG_INITIAL) n_flags = cfg_ch.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= '0;
            r_multi <= 1'b0;
            r_count <= '0;
            r_rd <= '0;
            r_wr <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_count <= n_count;
            r_rd <= n_rd;
            r_wr <= n_wr;
            r_ov <= n_ov;
            if (cfg_hit && cfg_ch.index == CFG_MULTI) r_multi <= cfg_ch.data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_otag <= n_otag;
        r_opat <= n_opat;
        r_last <= n_last;
    end

    // table write port: park at the tail, or move a survivor down
    always_ff @(posedge i_clk) begin
        if (mv_en) begin
            if (start) begin
                r_masks[r_count[IdxW-1:0]] <= c_pat;
                r_modes[r_count[IdxW-1:0]] <= c_mode;
                r_ids[r_count[IdxW-1:0]] <= c_tag;
            end else begin
                r_masks[wr_idx] <= e_mask;
                r_modes[wr_idx] <= e_mode;
                r_ids[wr_idx] <= e_id;
            end
        end
    end

    `EFU_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CntW'(WAITER_SLOTS))
    `EFU_ASSERT(a_wr_le_rd, i_clk, i_rst_n, r_wr <= r_rd)
    `EFU_ASSERT(a_pop_idle, i_clk, i_rst_n, o_pop |-> r_state == S_IDLE)
    `EFU_ASSERT(a_done_last, i_clk, i_rst_n, (r_ov && r_kind == K_DONE) |-> r_last)
endmodule

// ===== rtl/core/event_flag_unit.sv =====
// Event flag unit top level: front end, command queue and executor.
// Timing: a clear, wait or poll is done in the idle state; a set holds the
// executor while it checks the table, one table slot per cycle between wakes,
// and waits on output back-pressure for each woken waiter and the done result.
// Commands pass through the command queue; results leave from registers.
// Reset (i_rst_n, synchronous) empties the table, zeroes flags and control registers.
`timescale 1ns / 1ps
module event_flag_unit import efu_pkg::*; #(
    parameter int WAITER_SLOTS = WaiterSlotsDef,
    parameter int TAG_BITS = TagBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efu_in_if.sink    in_ch,
    efu_cfg_if.sink   cfg_ch,
    efu_out_if.source out_ch
);
    // queue word: op, pattern, mode, tag and the early bad-mode flag
    localparam int QW = 2 + PatW + ModeW + TAG_BITS + 1;

    logic q_empty;
    logic q_pop;
    logic [QW-1:0] q_cmd;

    // front end: take each transfer into the queue when there is room
    efu_front #(.TAG_BITS(TAG_BITS), .QW(QW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_pop(q_pop), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    // back end: one command at a time, scanning the waiter table for sets
    efu_back #(.WAITER_SLOTS(WAITER_SLOTS), .TAG_BITS(TAG_BITS), .QW(QW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg_ch(cfg_ch),
        .i_empty(q_empty), .i_cmd(q_cmd), .o_pop(q_pop), .out_ch(out_ch)
    );
endmodule
